[sv/dsil_pkg.sv]
// Package for the depth-sorted insertion list: list size, field widths,
// item and entry structs, and controller/datapath command and status types.
// Used by every module of the block.
package dsil_pkg;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned DEPTH_W    = 31;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_VERTEX = 2'd1,
    ACT_DRAIN  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] vertex_depth;
    logic               in_view;
    logic               last_vertex;
    logic [ID_W-1:0]    mesh_number;
    logic [ID_W-1:0]    poly_number;
  } in_item_t;

  typedef struct packed {
    logic                   entry_valid;
    logic [ID_W-1:0]        out_mesh;
    logic [ID_W-1:0]        out_poly;
    logic [DEPTH_W-1:0]     out_depth;
    logic                   accepted;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   last_result;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    mesh;
    logic [ID_W-1:0]    poly;
    logic [DEPTH_W-1:0] depth;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RESULT,
    ST_DR_RD,
    ST_DR_OUT
  } state_e;

  typedef enum logic [1:0] {
    RD_POS,
    RD_POS_M1,
    RD_POS_M2
  } rd_sel_e;

  typedef struct packed {
    logic    max_fold;
    logic    max_clr;
    logic    latch_item;
    logic    pos_load_count;
    logic    pos_clr;
    logic    pos_inc;
    logic    pos_dec;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    count_inc;
    logic    count_clr;
    logic    acc_set;
    logic    acc_clr;
    logic    load_result;
    logic    load_drain;
  } dsil_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic pos_one;
    logic shift;
    logic drain_last;
    logic out_free;
  } dsil_status_t;

endpackage

[sv/dsil_ctrl.sv]
// Controller of the depth-sorted insertion list: item decode and sequencing
// of insert, drain and result emission. Depends on dsil_pkg.
module dsil_ctrl import dsil_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [1:0]   in_action_i,
  input  logic         in_last_i,
  input  dsil_status_t status_i,
  output logic         in_ready_o,
  output dsil_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_e'(in_action_i))
            ACT_CLEAR:  state_d = ST_RESULT;
            ACT_VERTEX: begin
              if (in_last_i) state_d = status_i.full ? ST_RESULT : ST_INS_RD;
            end
            ACT_DRAIN:  state_d = status_i.empty ? ST_RESULT : ST_DR_RD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD: state_d = status_i.pos_zero ? ST_RESULT : ST_INS_CMP;
      ST_INS_CMP: begin
        if (!status_i.shift) state_d = ST_RESULT;
        else if (status_i.pos_one) state_d = ST_INS_RD;
      end
      ST_RESULT: if (status_i.out_free) state_d = ST_IDLE;
      ST_DR_RD:  state_d = ST_DR_OUT;
      ST_DR_OUT: begin
        if (status_i.out_free) state_d = status_i.drain_last ? ST_IDLE : ST_DR_RD;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_POS;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_e'(in_action_i))
            ACT_CLEAR: begin
              cmd_o.count_clr = 1'b1;
              cmd_o.max_clr   = 1'b1;
              cmd_o.acc_clr   = 1'b1;
            end
            ACT_VERTEX: begin
              cmd_o.max_fold = 1'b1;
              if (in_last_i) begin
                cmd_o.latch_item     = 1'b1;
                cmd_o.pos_load_count = 1'b1;
                cmd_o.acc_clr        = 1'b1;
                // dropped insert: the polygon ends here
                cmd_o.max_clr        = status_i.full;
              end
            end
            ACT_DRAIN: begin
              cmd_o.acc_clr = 1'b1;
              cmd_o.pos_clr = 1'b1;
            end
            default: cmd_o.acc_clr = 1'b0;
          endcase
        end
      end
      ST_INS_RD: begin
        if (status_i.pos_zero) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_new    = 1'b1;
          cmd_o.count_inc = 1'b1;
          cmd_o.acc_set   = 1'b1;
          cmd_o.max_clr   = 1'b1;
        end else begin
          cmd_o.rd_sel = RD_POS_M1;
        end
      end
      ST_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.shift) begin
          // move the nearer entry down one slot, fetch the next one up
          cmd_o.pos_dec = 1'b1;
          cmd_o.rd_sel  = RD_POS_M2;
        end else begin
          cmd_o.wr_new    = 1'b1;
          cmd_o.count_inc = 1'b1;
          cmd_o.acc_set   = 1'b1;
          cmd_o.max_clr   = 1'b1;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_result = 1'b1;
        end
      end
      ST_DR_RD: cmd_o.rd_sel = RD_POS;
      ST_DR_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_drain = 1'b1;
          cmd_o.pos_inc    = !status_i.drain_last;
        end
      end
      default: cmd_o.rd_sel = RD_POS;
    endcase
  end

endmodule

[sv/dsil_dp.sv]
// Datapath of the depth-sorted insertion list: entry memory, count, running
// depth maximum, scan position and the output register. Depends on dsil_pkg.
module dsil_dp import dsil_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  in_item_t     in_data_i,
  input  dsil_cmd_t    cmd_i,
  input  logic         out_ready_i,
  output dsil_status_t status_o,
  output logic         out_valid_o,
  output out_item_t    out_data_o
);

  entry_t             mem [LIST_DEPTH];
  entry_t             rdata_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   pos_q;
  logic [DEPTH_W-1:0] max_q;
  logic [ID_W-1:0]    mesh_q;
  logic [ID_W-1:0]    poly_q;
  logic               acc_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [CNT_W-1:0]   rd_pos;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             new_entry;
  entry_t             wr_data;
  logic               fold_hit;

  assign new_entry = '{mesh: mesh_q, poly: poly_q, depth: max_q};
  assign wr_data   = cmd_i.wr_new ? new_entry : rdata_q;
  assign wr_addr   = pos_q[IDX_W-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      RD_POS_M1: rd_pos = pos_q - CNT_W'(1);
      RD_POS_M2: rd_pos = pos_q - CNT_W'(2);
      default:   rd_pos = pos_q;
    endcase
  end
  assign rd_addr = rd_pos[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  assign fold_hit = in_data_i.in_view && !in_data_i.vertex_depth[31] &&
                    (in_data_i.vertex_depth[DEPTH_W-1:0] > max_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      max_q       <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.count_clr)      count_q <= '0;
      else if (cmd_i.count_inc) count_q <= count_q + CNT_W'(1);

      if (cmd_i.pos_load_count) pos_q <= count_q;
      else if (cmd_i.pos_clr)   pos_q <= '0;
      else if (cmd_i.pos_dec)   pos_q <= pos_q - CNT_W'(1);
      else if (cmd_i.pos_inc)   pos_q <= pos_q + CNT_W'(1);

      if (cmd_i.max_clr)                  max_q <= '0;
      else if (cmd_i.max_fold && fold_hit) max_q <= in_data_i.vertex_depth[DEPTH_W-1:0];

      if (cmd_i.acc_set)      acc_q <= 1'b1;
      else if (cmd_i.acc_clr) acc_q <= 1'b0;

      if (cmd_i.load_result || cmd_i.load_drain) out_valid_q <= 1'b1;
      else if (out_ready_i)                      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      mesh_q <= in_data_i.mesh_number;
      poly_q <= in_data_i.poly_number;
    end
    if (cmd_i.load_result) begin
      out_q.entry_valid <= 1'b0;
      out_q.out_mesh    <= '0;
      out_q.out_poly    <= '0;
      out_q.out_depth   <= '0;
      out_q.accepted    <= acc_q;
      out_q.entry_count <= COUNT_OUT_W'(count_q);
      out_q.last_result <= 1'b1;
    end else if (cmd_i.load_drain) begin
      out_q.entry_valid <= 1'b1;
      out_q.out_mesh    <= rdata_q.mesh;
      out_q.out_poly    <= rdata_q.poly;
      out_q.out_depth   <= rdata_q.depth;
      out_q.accepted    <= 1'b0;
      out_q.entry_count <= COUNT_OUT_W'(count_q);
      out_q.last_result <= status_o.drain_last;
    end
  end

  assign status_o.full       = (count_q == CNT_W'(LIST_DEPTH));
  assign status_o.empty      = (count_q == '0);
  assign status_o.pos_zero   = (pos_q == '0);
  assign status_o.pos_one    = (pos_q == CNT_W'(1));
  // strict compare: a new entry stays behind entries of equal depth
  assign status_o.shift      = (max_q > rdata_q.depth);
  assign status_o.drain_last = (pos_q == count_q - CNT_W'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/depth_sorted_insertion_list_top.sv]
// Top level of the depth-sorted insertion list: controller plus datapath.
// Depends on dsil_pkg, dsil_ctrl and dsil_dp.
//
// Usage: items arrive on in_valid_i/in_ready_o as in_item_t, results leave
// on out_valid_o/out_ready_i as out_item_t through one output register.
// A vertex item that is not the last of its polygon folds its depth into the
// running maximum and gives no result; the next item can follow immediately.
// A clear moves to the result state, which loads its result into the output
// register once that register is free.
// A last vertex inserts by scanning the list from its tail, one entry per
// cycle through the entry memory's separate read and write ports; an insert
// into a full list is dropped.
// A drain emits its results farthest first, each by a memory read, then an
// output load; an empty list gives a single result with entry_valid 0.
// Only one item is in work at a time; in_ready_o is high while idle.
// When the receiver stalls, the finished result is held in the output
// register and the controller waits before loading the next one.
// Reset clears the count, the running maximum and the control state; the
// entry memory is not cleared since only held entries are ever read.
module depth_sorted_insertion_list_top import dsil_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dsil_cmd_t    cmd;
  dsil_status_t status;

  dsil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_last_i   (in_data_i.last_vertex),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  dsil_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[verif/dsil_list_checker.sv]
// Checker for the depth-sorted insertion list: watches both channels, keeps
// its own copy of the list to predict every result, and compares them.
// Depends on dsil_pkg.
module dsil_list_checker import dsil_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        errors_o,
  output int        pending_o,
  output int        results_o,
  output int        drained_o,
  output int        dropped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t             depth_list[$];  // farthest first
  logic [DEPTH_W-1:0] peak_depth;     // deepest in-view vertex of the polygon under way
  out_item_t          expected_q[$];

  function automatic string fmt_result(input out_item_t r);
    return $sformatf("valid %0b mesh %h poly %h depth %h acc %0b count %0d last %0b",
                     r.entry_valid, r.out_mesh, r.out_poly, r.out_depth, r.accepted,
                     r.entry_count, r.last_result);
  endfunction

  task automatic predict_item(input in_item_t it);
    out_item_t r;
    entry_t    e;
    int        pos;
    r = '0;
    r.last_result = 1'b1;
    case (it.action)
      ACT_CLEAR: begin
        depth_list.delete();
        peak_depth = '0;
        expected_q.push_back(r);
      end
      ACT_VERTEX: begin
        if (it.in_view && !it.vertex_depth[31] &&
            it.vertex_depth[DEPTH_W-1:0] > peak_depth)
          peak_depth = it.vertex_depth[DEPTH_W-1:0];
        if (it.last_vertex) begin
          if (depth_list.size() < LIST_DEPTH) begin
            // ties keep arrival order: stop only at a strictly nearer entry
            pos = 0;
            while (pos < depth_list.size() && depth_list[pos].depth >= peak_depth) pos++;
            e.mesh  = it.mesh_number;
            e.poly  = it.poly_number;
            e.depth = peak_depth;
            depth_list.insert(pos, e);
            r.accepted = 1'b1;
          end else begin
            dropped_o++;
          end
          peak_depth    = '0;
          r.entry_count = COUNT_OUT_W'(depth_list.size());
          expected_q.push_back(r);
        end
      end
      ACT_DRAIN: begin
        if (depth_list.size() == 0) expected_q.push_back(r);
        foreach (depth_list[i]) begin
          r.entry_valid = 1'b1;
          r.out_mesh    = depth_list[i].mesh;
          r.out_poly    = depth_list[i].poly;
          r.out_depth   = depth_list[i].depth;
          r.entry_count = COUNT_OUT_W'(depth_list.size());
          r.last_result = (i == depth_list.size() - 1);
          expected_q.push_back(r);
        end
      end
      default: ;  // unused action: no effect
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_o++;
    if (expected_q.size() == 0) begin
      errors_o++;
      if (errors_o <= 10) $display("%0t: result with nothing expected: %s", $time,
                                   fmt_result(got));
    end else begin
      want = expected_q.pop_front();
      if (got.entry_valid !== want.entry_valid || got.out_mesh !== want.out_mesh ||
          got.out_poly !== want.out_poly || got.out_depth !== want.out_depth ||
          got.accepted !== want.accepted || got.entry_count !== want.entry_count ||
          got.last_result !== want.last_result) begin
        errors_o++;
        if (errors_o <= 10) begin
          $display("%0t: mismatch", $time);
          $display("  expected %s", fmt_result(want));
          $display("  actual   %s", fmt_result(got));
        end
      end
      if (want.entry_valid) drained_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_list.delete();
      expected_q.delete();
      peak_depth = '0;
      errors_o   = 0;
      pending_o  = 0;
      results_o  = 0;
      drained_o  = 0;
      dropped_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      pending_o = expected_q.size();
    end
  end

endmodule

[verif/tb_depth_sorted_insertion_list_top.sv]
// Testbench top for depth_sorted_insertion_list_top: drives directed and
// random vertex/clear/drain items with random idling on both channels.
// Depends on dsil_pkg, the block's RTL and dsil_list_checker.
module tb_depth_sorted_insertion_list_top import dsil_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  int errors, pending, results, drained, dropped;
  int send_idle_pct = 35;
  int recv_idle_pct = 81;
  int work_items    = 0;  // accepted items other than the unused action
  int inserts_since_clear = 0;

  depth_sorted_insertion_list_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  dsil_list_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results),
    .drained_o   (drained),
    .dropped_o   (dropped)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #(8_000_000);
    $display("Timeout: items or results stopped moving");
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_item_t make_item(input action_e act, input logic [31:0] depth,
                                         input logic view, input logic last,
                                         input logic [ID_W-1:0] mesh,
                                         input logic [ID_W-1:0] poly);
    in_item_t it;
    it.action       = act;
    it.vertex_depth = depth;
    it.in_view      = view;
    it.last_vertex  = last;
    it.mesh_number  = mesh;
    it.poly_number  = poly;
    return it;
  endfunction

  // vertex fields are don't-care for these actions, so fill them with noise
  function automatic in_item_t ctrl_item(input action_e act);
    return make_item(act, $urandom, 1'($urandom), 1'($urandom), 16'($urandom),
                     16'($urandom));
  endfunction

  // only clear once the list has had the chance to fill up
  function automatic in_item_t flush_item();
    return ctrl_item(inserts_since_clear >= LIST_DEPTH ? ACT_CLEAR : ACT_DRAIN);
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return {14'd0, 2'($urandom_range(0, 3)), 16'h0};  // few values, many ties
      2: return {1'b0, 31'($urandom)};
      3: return {1'b1, 31'($urandom)};
      default: return {16'($urandom_range(0, 7)), 16'($urandom)};
    endcase
  endfunction

  // Called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (it.action != ACT_NONE) work_items++;
    if (it.action == ACT_CLEAR) inserts_since_clear = 0;
    if (it.action == ACT_VERTEX && it.last_vertex) inserts_since_clear++;
  endtask

  task automatic send_polygon();
    logic [ID_W-1:0] mesh, poly;
    int              n, i;
    n    = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 4);
    mesh = 16'($urandom);
    poly = 16'($urandom);
    for (i = 0; i < n; i++)
      send_item(make_item(ACT_VERTEX, rand_depth(), $urandom_range(0, 9) != 0,
                          i == n - 1, mesh, poly));
  endtask

  initial begin
    int ph, phase_end, pick;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty list, depth extremes, ties, ignored action, interrupted polygons
    send_item(make_item(ACT_DRAIN, '0, 1'b0, 1'b0, '0, '0));
    send_item(make_item(ACT_CLEAR, '1, 1'b1, 1'b1, '1, '1));
    send_item(make_item(ACT_VERTEX, 32'h7FFF_FFFF, 1'b1, 1'b0, '0, '0));
    send_item(make_item(ACT_VERTEX, 32'h8000_0000, 1'b1, 1'b1, '1, '1));
    send_item(make_item(ACT_VERTEX, 32'h7FFF_FFFF, 1'b0, 1'b1, 16'd1, 16'd1));
    send_item(make_item(ACT_VERTEX, 32'h0000_0000, 1'b1, 1'b1, 16'd1, 16'd2));
    send_item(make_item(ACT_VERTEX, 32'h0001_0000, 1'b1, 1'b1, 16'd2, 16'd0));
    send_item(make_item(ACT_VERTEX, 32'h0003_0000, 1'b1, 1'b0, 16'd3, 16'd0));
    send_item(make_item(ACT_VERTEX, 32'h0002_0000, 1'b1, 1'b1, 16'd3, 16'd0));
    send_item(make_item(ACT_VERTEX, 32'h0003_0000, 1'b1, 1'b1, 16'd4, 16'd0));
    send_item(make_item(ACT_VERTEX, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'd5, 16'd0));
    send_item(make_item(ACT_VERTEX, 32'h0005_0000, 1'b1, 1'b0, 16'd6, 16'd0));
    send_item(make_item(ACT_NONE, '1, 1'b1, 1'b1, '1, '1));
    send_item(make_item(ACT_VERTEX, 32'h0000_0001, 1'b1, 1'b1, 16'd6, 16'd1));
    send_item(make_item(ACT_DRAIN, '1, 1'b1, 1'b1, '1, '1));
    send_item(make_item(ACT_VERTEX, 32'h0006_0000, 1'b1, 1'b0, 16'd7, 16'd0));
    send_item(make_item(ACT_DRAIN, '0, 1'b0, 1'b0, '0, '0));
    send_item(make_item(ACT_VERTEX, 32'h0000_0000, 1'b1, 1'b1, 16'd7, 16'd1));
    send_item(make_item(ACT_VERTEX, 32'h0004_0000, 1'b1, 1'b0, 16'd8, 16'd0));
    send_item(make_item(ACT_CLEAR, '0, 1'b0, 1'b0, '0, '0));
    send_item(make_item(ACT_VERTEX, 32'h0000_0000, 1'b1, 1'b1, 16'd8, 16'd1));
    send_item(make_item(ACT_DRAIN, '0, 1'b0, 1'b0, '0, '0));

    // random: mostly whole polygons, each phase long enough to fill the list
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 35 : 0;
      phase_end     = work_items + 136;
      send_item(ctrl_item(ACT_CLEAR));
      while (work_items < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          send_polygon();
        end else if (pick < 85) begin
          send_item(ctrl_item(ACT_DRAIN));
        end else if (pick < 88) begin
          send_item(ctrl_item(ACT_NONE));
        end else if (pick < 95) begin
          // polygon cut by a drain or clear between its vertices
          repeat ($urandom_range(1, 2))
            send_item(make_item(ACT_VERTEX, rand_depth(), 1'($urandom), 1'b0,
                                16'($urandom), 16'($urandom)));
          send_item(flush_item());
        end else begin
          send_item(flush_item());
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);

    $display("Ran %0d items (vertex, clear, drain) through three idling phases",
             work_items);
    $display("Checked %0d results: %0d drained entries, %0d inserts dropped on a full list",
             results, drained, dropped);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
